/* design/cleb_pkg.sv */
// ----------------------------------------------------------------------------
// cleb_pkg
// Shared types and key codes for the console line edit buffer.
// ----------------------------------------------------------------------------
package cleb_pkg;

  localparam logic FUNC_RX   = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  localparam logic [7:0] KEY_KILL = 8'h15;
  localparam logic [7:0] KEY_BS   = 8'h08;
  localparam logic [7:0] KEY_DEL  = 8'h7f;
  localparam logic [7:0] KEY_EOT  = 8'h04;
  localparam logic [7:0] KEY_CR   = 8'h0d;
  localparam logic [7:0] KEY_LF   = 8'h0a;
  localparam logic [7:0] KEY_NUL  = 8'h00;
  localparam logic [7:0] ERASE_SAT = 8'hff;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_char;
  } in_item_t;

  typedef struct packed {
    logic       echo_valid;
    logic [7:0] echo_char;
    logic [7:0] erase_count;
    logic       line_committed;
    logic       read_valid;
    logic [7:0] read_char;
  } out_item_t;

  typedef struct packed {
    logic       en;
    logic [7:0] data;
  } wr_ctl_t;

endpackage

/* design/cleb_ram.sv */
// ----------------------------------------------------------------------------
// cleb_ram
// Line store: one write port, one registered read port with write bypass.
// ----------------------------------------------------------------------------
module cleb_ram #(
  parameter int DEPTH = 128
) (
  input  logic                       clk,
  input  cleb_pkg::wr_ctl_t          wr,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic [7:0]                 rd_data
);

  logic [7:0] mem_r [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr_addr] <= wr.data;
    end
  end

  // same-cycle write to the prefetched entry is forwarded
  always_ff @(posedge clk) begin
    if (wr.en && (wr_addr == rd_addr)) begin
      rd_data_r <= wr.data;
    end else begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* design/cleb_edit.sv */
// ----------------------------------------------------------------------------
// cleb_edit
// Read, commit and edit indices and the per-transaction edit decode.
// ----------------------------------------------------------------------------
module cleb_edit #(
  parameter int DEPTH = 128
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       item_valid,
  input  cleb_pkg::in_item_t         item,
  input  logic [7:0]                 rd_data,
  output cleb_pkg::wr_ctl_t          wr,
  output logic [$clog2(DEPTH)-1:0]   wr_addr,
  output logic [$clog2(DEPTH)-1:0]   rd_addr,
  output cleb_pkg::out_item_t        result
);

  localparam int IW = $clog2(2 * DEPTH);
  localparam int AW = $clog2(DEPTH);
  localparam int XW = (IW > 8) ? IW : 8;
  localparam logic [IW-1:0] IDX_DEPTH = IW'(DEPTH);
  localparam logic [IW-1:0] IDX_LAST  = IW'(2 * DEPTH - 1);
  localparam logic [IW-1:0] IDX_MOD   = IW'(2 * DEPTH);

  logic [IW-1:0] read_idx_r, read_idx_nxt;
  logic [IW-1:0] commit_idx_r, commit_idx_nxt;
  logic [IW-1:0] edit_idx_r, edit_idx_nxt;

  logic [IW-1:0] uncommitted;
  logic [IW-1:0] fill;
  logic [XW-1:0] kill_ext;
  logic [7:0]    stored_char;

  function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] a);
    return (a == IDX_LAST) ? '0 : a + IW'(1);
  endfunction

  function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] a);
    return (a == '0) ? IDX_LAST : a - IW'(1);
  endfunction

  function automatic logic [IW-1:0] idx_diff(input logic [IW-1:0] a,
                                              input logic [IW-1:0] b);
    return (a >= b) ? (a - b) : (a + IDX_MOD - b);
  endfunction

  function automatic logic [AW-1:0] idx_addr(input logic [IW-1:0] a);
    logic [IW-1:0] t;
    t = (a >= IDX_DEPTH) ? (a - IDX_DEPTH) : a;
    return t[AW-1:0];
  endfunction

  assign uncommitted = idx_diff(edit_idx_r, commit_idx_r);
  assign fill        = idx_diff(edit_idx_r, read_idx_r);
  assign kill_ext    = XW'(uncommitted);
  assign stored_char = (item.rx_char == cleb_pkg::KEY_CR) ? cleb_pkg::KEY_LF : item.rx_char;

  always_comb begin
    read_idx_nxt   = read_idx_r;
    commit_idx_nxt = commit_idx_r;
    edit_idx_nxt   = edit_idx_r;
    result         = '0;
    wr.en          = 1'b0;
    wr.data        = stored_char;
    wr_addr        = idx_addr(edit_idx_r);
    if (item_valid) begin
      priority if (item.func == cleb_pkg::FUNC_READ) begin
        if (read_idx_r != commit_idx_r) begin
          result.read_valid = 1'b1;
          result.read_char  = rd_data;
          read_idx_nxt      = idx_inc(read_idx_r);
        end
      end else if (item.rx_char == cleb_pkg::KEY_KILL) begin
        edit_idx_nxt       = commit_idx_r;
        result.erase_count = (kill_ext > XW'(255)) ? cleb_pkg::ERASE_SAT : kill_ext[7:0];
      end else if ((item.rx_char == cleb_pkg::KEY_BS) ||
                   (item.rx_char == cleb_pkg::KEY_DEL)) begin
        if (edit_idx_r != commit_idx_r) begin
          edit_idx_nxt       = idx_dec(edit_idx_r);
          result.erase_count = 8'd1;
        end
      end else if ((item.rx_char != cleb_pkg::KEY_NUL) && (fill < IDX_DEPTH)) begin
        wr.en             = 1'b1;
        edit_idx_nxt      = idx_inc(edit_idx_r);
        result.echo_valid = 1'b1;
        result.echo_char  = stored_char;
        if ((stored_char == cleb_pkg::KEY_LF) || (stored_char == cleb_pkg::KEY_EOT) ||
            (fill == IDX_DEPTH - IW'(1))) begin
          commit_idx_nxt        = idx_inc(edit_idx_r);
          result.line_committed = 1'b1;
        end
      end else begin
        result = '0;
      end
    end
  end

  // prefetch the entry at the next read index
  assign rd_addr = rst_n ? idx_addr(read_idx_nxt) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      read_idx_r   <= '0;
      commit_idx_r <= '0;
      edit_idx_r   <= '0;
    end else begin
      read_idx_r   <= read_idx_nxt;
      commit_idx_r <= commit_idx_nxt;
      edit_idx_r   <= edit_idx_nxt;
    end
  end

endmodule

/* design/console_line_edit_buffer_top.sv */
// ----------------------------------------------------------------------------
// console_line_edit_buffer_top
// Terminal line editor over a ring buffer with read, commit and edit indices.
// ----------------------------------------------------------------------------
//  channel  | ports                      | handshake
//  ---------+----------------------------+------------------------------------
//  input    | start, busy, in_item       | taken when start && !busy
//  result   | out_strobe, out_item       | one cycle per result, no back-pressure
//
//  one transaction per cycle; busy is never raised
//  each result is strobed after its transaction passes the input registers
//  (in_valid_r, in_item_r) and then the output registers (out_strobe_r, out_item_r)
//  the read port prefetches the entry at the read index, one registered read
//  reset is synchronous; indices clear to zero, the line store is not cleared
//  the receiver cannot stall, so there is no output queue
// ----------------------------------------------------------------------------
module console_line_edit_buffer_top #(
  parameter int BUFFER_DEPTH = 128
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  cleb_pkg::in_item_t   in_item,
  output logic                 out_strobe,
  output cleb_pkg::out_item_t  out_item
);

  localparam int AW = $clog2(BUFFER_DEPTH);

  logic                 in_valid_r;
  cleb_pkg::in_item_t   in_item_r;
  logic                 out_strobe_r;
  cleb_pkg::out_item_t  out_item_r;
  cleb_pkg::out_item_t  result;
  cleb_pkg::wr_ctl_t    wr;
  logic [AW-1:0]        wr_addr;
  logic [AW-1:0]        rd_addr;
  logic [7:0]           rd_data;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      in_valid_r   <= start && !busy;
      out_strobe_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    in_item_r  <= in_item;
    out_item_r <= result;
  end

  cleb_edit #(
    .DEPTH (BUFFER_DEPTH)
  ) u_edit (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_valid_r),
    .item       (in_item_r),
    .rd_data    (rd_data),
    .wr         (wr),
    .wr_addr    (wr_addr),
    .rd_addr    (rd_addr),
    .result     (result)
  );

  cleb_ram #(
    .DEPTH (BUFFER_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr      (wr),
    .wr_addr (wr_addr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

/* design/cleb_checker.sv */
// ----------------------------------------------------------------------------
// cleb_checker
// Port-level checks on transaction timing and result field consistency.
// ----------------------------------------------------------------------------
module cleb_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input cleb_pkg::out_item_t  out_item,
  input logic                 out_strobe
);

  a_result_follows : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_strobe)
    else $error("result missing two cycles after a transaction");

  a_no_spurious : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy && rst_n, 2))
    else $error("result without a transaction");

  a_read_exclusive : assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.read_valid) |->
      (!out_item.echo_valid && !out_item.line_committed && (out_item.erase_count == 8'd0)))
    else $error("read result mixed with edit fields");

  a_echo_char : assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.echo_valid) |->
      ((out_item.echo_char != cleb_pkg::KEY_NUL) &&
       (out_item.echo_char != cleb_pkg::KEY_CR) &&
       (out_item.erase_count == 8'd0)))
    else $error("bad echoed character");

  a_commit_echo : assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.line_committed) |-> out_item.echo_valid)
    else $error("commit without a stored character");

endmodule

bind console_line_edit_buffer_top cleb_checker u_cleb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_item   (out_item),
  .out_strobe (out_strobe)
);

/* tb/console_line_edit_buffer_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// console_line_edit_buffer_top_tb
// Drives received bytes and consumer reads into the line editor, runs a
// table of directed transactions and then a long random run that types, edits,
// fills and drains the ring. Every result is checked field by field against its
// pinned row, else a cycle-free model of the indices and line store alongside.
// ----------------------------------------------------------------------------
module console_line_edit_buffer_top_tb;

  localparam int DEPTH      = 128;
  localparam int RAND_ITEMS = 700;
  localparam int DIR_ROWS   = 26;
  localparam int LIMIT      = 200000;
  localparam int SETTLE     = 8;

  localparam cleb_pkg::out_item_t NO_EFFECT = '0;
  localparam cleb_pkg::out_item_t ERASE_ONE = '{1'b0, 8'h00, 8'h01, 1'b0, 1'b0, 8'h00};

  typedef enum {MODE_TYPE, MODE_FILL, MODE_DRAIN} feed_mode_t;

  typedef struct {
    logic                func;
    logic [7:0]          ch;
    bit                  pinned;
    cleb_pkg::out_item_t want;
  } dir_row_t;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  cleb_pkg::in_item_t  in_item;
  logic                out_strobe;
  cleb_pkg::out_item_t out_item;

  logic                pin_en;
  cleb_pkg::out_item_t pin_want;

  logic [7:0] line_mem [DEPTH];
  logic [7:0] rd_idx;
  logic [7:0] cm_idx;
  logic [7:0] ed_idx;

  cleb_pkg::out_item_t pending_results [$];
  int        fault_cnt;
  int        cyc_cnt;
  int        burst_left;
  dir_row_t  dir_tab [DIR_ROWS];

  console_line_edit_buffer_top #(
    .BUFFER_DEPTH(DEPTH)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic cleb_pkg::out_item_t edit_line(cleb_pkg::in_item_t it);
    cleb_pkg::out_item_t r;
    logic [7:0]          c;
    logic [7:0]          fill;
    r = '0;
    c = it.rx_char;
    fill = ed_idx - rd_idx;
    if (it.func == cleb_pkg::FUNC_READ) begin
      if (rd_idx != cm_idx) begin
        r.read_valid = 1'b1;
        r.read_char = line_mem[rd_idx % DEPTH];
        rd_idx = rd_idx + 8'd1;
      end
    end else if (c == cleb_pkg::KEY_KILL) begin
      r.erase_count = ed_idx - cm_idx;
      ed_idx = cm_idx;
    end else if (c == cleb_pkg::KEY_BS || c == cleb_pkg::KEY_DEL) begin
      if (ed_idx != cm_idx) begin
        ed_idx = ed_idx - 8'd1;
        r.erase_count = 8'd1;
      end
    end else if (c != cleb_pkg::KEY_NUL && fill < DEPTH) begin
      if (c == cleb_pkg::KEY_CR) begin
        c = cleb_pkg::KEY_LF;
      end
      line_mem[ed_idx % DEPTH] = c;
      ed_idx = ed_idx + 8'd1;
      r.echo_valid = 1'b1;
      r.echo_char = c;
      fill = ed_idx - rd_idx;
      if (c == cleb_pkg::KEY_LF || c == cleb_pkg::KEY_EOT || fill == DEPTH) begin
        cm_idx = ed_idx;
        r.line_committed = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic check_result(cleb_pkg::out_item_t want, cleb_pkg::out_item_t got);
    if (got.echo_valid !== want.echo_valid) begin
      $error("echo_valid expected %0h got %0h", want.echo_valid, got.echo_valid);
      fault_cnt++;
    end
    if (got.echo_char !== want.echo_char) begin
      $error("echo_char expected %0h got %0h", want.echo_char, got.echo_char);
      fault_cnt++;
    end
    if (got.erase_count !== want.erase_count) begin
      $error("erase_count expected %0h got %0h", want.erase_count, got.erase_count);
      fault_cnt++;
    end
    if (got.line_committed !== want.line_committed) begin
      $error("line_committed expected %0h got %0h", want.line_committed,
             got.line_committed);
      fault_cnt++;
    end
    if (got.read_valid !== want.read_valid) begin
      $error("read_valid expected %0h got %0h", want.read_valid, got.read_valid);
      fault_cnt++;
    end
    if (got.read_char !== want.read_char) begin
      $error("read_char expected %0h got %0h", want.read_char, got.read_char);
      fault_cnt++;
    end
  endtask

  always @(posedge clk) begin : monitor
    cleb_pkg::out_item_t want;
    if (rst_n === 1'b1 && start === 1'b1 && busy !== 1'b1) begin
      want = edit_line(in_item);
      if (pin_en) begin
        want = pin_want;
      end
      pending_results.push_back(want);
    end
    if (rst_n === 1'b1 && out_strobe !== 1'b0) begin
      if (pending_results.size() == 0) begin
        $error("result with no transaction pending");
        fault_cnt++;
      end else begin
        check_result(pending_results.pop_front(), out_item);
      end
    end
  end

  always @(posedge clk) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt >= LIMIT) begin
      $display("console_line_edit_buffer_top_tb failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 8) begin
      burst_left = $urandom_range(10, 40);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_key(feed_mode_t m);
    int r;
    r = $urandom_range(0, 99);
    if (m == MODE_FILL) begin
      if (r < 2) return ($urandom_range(0, 1) != 0) ? cleb_pkg::KEY_BS : cleb_pkg::KEY_DEL;
      if (r < 3) return cleb_pkg::KEY_KILL;
      if (r < 4) return cleb_pkg::KEY_NUL;
      if (r < 10) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(8'h20, 8'h7e));
    end
    if (r < 6) return cleb_pkg::KEY_LF;
    if (r < 9) return cleb_pkg::KEY_CR;
    if (r < 11) return cleb_pkg::KEY_EOT;
    if (r < 17) return ($urandom_range(0, 1) != 0) ? cleb_pkg::KEY_BS : cleb_pkg::KEY_DEL;
    if (r < 19) return cleb_pkg::KEY_KILL;
    if (r < 20) return cleb_pkg::KEY_NUL;
    if (r < 30) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(8'h20, 8'h7e));
  endfunction

  task automatic send_item(cleb_pkg::in_item_t it, bit pinned, cleb_pkg::out_item_t want);
    int gap;
    start <= 1'b1;
    in_item <= it;
    pin_en <= pinned;
    pin_want <= want;
    @(posedge clk);
    while (busy === 1'b1) @(posedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      in_item <= cleb_pkg::in_item_t'($urandom);
      pin_en <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin : main
    feed_mode_t         mode;
    int                 mode_left;
    int                 read_pct;
    cleb_pkg::in_item_t it;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    pin_en = 1'b0;
    pin_want = '0;
    burst_left = 0;
    rd_idx = '0;
    cm_idx = '0;
    ed_idx = '0;
    foreach (line_mem[i]) line_mem[i] = '0;

    dir_tab = '{
      '{cleb_pkg::FUNC_READ, cleb_pkg::KEY_NUL,  1'b1, NO_EFFECT},
      '{cleb_pkg::FUNC_RX,   cleb_pkg::KEY_NUL,  1'b1, NO_EFFECT},
      '{cleb_pkg::FUNC_RX,   cleb_pkg::KEY_BS,   1'b1, NO_EFFECT},
      '{cleb_pkg::FUNC_RX,   cleb_pkg::KEY_DEL,  1'b1, NO_EFFECT},
      '{cleb_pkg::FUNC_RX,   cleb_pkg::KEY_KILL, 1'b1, NO_EFFECT},
      '{cleb_pkg::FUNC_RX,   8'h61,              1'b1,
        '{1'b1, 8'h61, 8'h00, 1'b0, 1'b0, 8'h00}},
      '{cleb_pkg::FUNC_RX,   8'h62,              1'b0, NO_EFFECT},
      '{cleb_pkg::FUNC_RX,   cleb_pkg::KEY_BS,   1'b1, ERASE_ONE},
      '{cleb_pkg::FUNC_RX,   cleb_pkg::KEY_DEL,  1'b1, ERASE_ONE},
      '{cleb_pkg::FUNC_RX,   cleb_pkg::KEY_DEL,  1'b1, NO_EFFECT},
      '{cleb_pkg::FUNC_RX,   8'h01,              1'b0, NO_EFFECT},
      '{cleb_pkg::FUNC_RX,   8'hff,              1'b0, NO_EFFECT},
      '{cleb_pkg::FUNC_RX,   8'h80,              1'b0, NO_EFFECT},
      '{cleb_pkg::FUNC_RX,   cleb_pkg::KEY_KILL, 1'b1,
        '{1'b0, 8'h00, 8'h03, 1'b0, 1'b0, 8'h00}},
      '{cleb_pkg::FUNC_RX,   8'hff,              1'b1,
        '{1'b1, 8'hff, 8'h00, 1'b0, 1'b0, 8'h00}},
      '{cleb_pkg::FUNC_RX,   cleb_pkg::KEY_CR,   1'b1,
        '{1'b1, cleb_pkg::KEY_LF, 8'h00, 1'b1, 1'b0, 8'h00}},
      '{cleb_pkg::FUNC_READ, cleb_pkg::KEY_KILL, 1'b1,
        '{1'b0, 8'h00, 8'h00, 1'b0, 1'b1, 8'hff}},
      '{cleb_pkg::FUNC_READ, 8'hff,              1'b1,
        '{1'b0, 8'h00, 8'h00, 1'b0, 1'b1, cleb_pkg::KEY_LF}},
      '{cleb_pkg::FUNC_READ, 8'h00,              1'b1, NO_EFFECT},
      '{cleb_pkg::FUNC_RX,   8'h7e,              1'b0, NO_EFFECT},
      '{cleb_pkg::FUNC_RX,   cleb_pkg::KEY_EOT,  1'b0, NO_EFFECT},
      '{cleb_pkg::FUNC_RX,   cleb_pkg::KEY_LF,   1'b0, NO_EFFECT},
      '{cleb_pkg::FUNC_RX,   cleb_pkg::KEY_KILL, 1'b1, NO_EFFECT},
      '{cleb_pkg::FUNC_READ, 8'h00,              1'b0, NO_EFFECT},
      '{cleb_pkg::FUNC_READ, 8'haa,              1'b0, NO_EFFECT},
      '{cleb_pkg::FUNC_READ, 8'h55,              1'b0, NO_EFFECT}
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      it.func = dir_tab[i].func;
      it.rx_char = dir_tab[i].ch;
      send_item(it, dir_tab[i].pinned, dir_tab[i].want);
    end

    // open with a fill phase so the ring reaches full early
    mode = MODE_FILL;
    mode_left = $urandom_range(140, 200);
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (mode_left == 0) begin
        case ($urandom_range(0, 3))
          0: begin
            mode = MODE_FILL;
            mode_left = $urandom_range(100, 200);
          end
          1: begin
            mode = MODE_DRAIN;
            mode_left = $urandom_range(30, 120);
          end
          default: begin
            mode = MODE_TYPE;
            mode_left = $urandom_range(30, 100);
          end
        endcase
      end
      mode_left--;
      case (mode)
        MODE_FILL:  read_pct = 3;
        MODE_DRAIN: read_pct = 85;
        default:    read_pct = 35;
      endcase
      if ($urandom_range(0, 99) < read_pct) begin
        it.func = cleb_pkg::FUNC_READ;
        it.rx_char = 8'($urandom_range(0, 255));
      end else begin
        it.func = cleb_pkg::FUNC_RX;
        it.rx_char = pick_key(mode);
      end
      send_item(it, 1'b0, NO_EFFECT);
    end

    start <= 1'b0;
    pin_en <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (fault_cnt == 0) begin
      $display("console_line_edit_buffer_top_tb passed");
    end else begin
      $display("console_line_edit_buffer_top_tb failed");
    end
    $finish;
  end

endmodule
